// ----- hdl/fpa_pkg.sv -----
package fpa_pkg;

    localparam int NUM_PARTITIONS = 6;
    localparam int NUM_CFG        = 6;
    localparam int IDX_W          = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
    localparam int CFG_IDX_W      = 3;
    localparam int CAP_W          = 8;
    localparam int PID_W          = 16;
    localparam int MEM_W          = 11;
    localparam int PART_W         = 3;

    localparam logic [CAP_W-1:0] CAP_RESET [NUM_CFG] = '{
        8'd40, 8'd25, 8'd15, 8'd10, 8'd8, 8'd2
    };

    typedef enum logic [0:0] {
        K_ALLOC   = 1'b0,
        K_RELEASE = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_GRANTED   = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_RELEASED  = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SUM,
        S_FINAL,
        S_DONE
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic [PID_W-1:0]   process_id;
        logic [CAP_W-1:0]   request_size;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [PART_W-1:0]  partition_number;
        logic [MEM_W-1:0]   memory_used;
        logic [MEM_W-1:0]   total_free;
        logic [MEM_W-1:0]   usable_free;
    } t_rsp;

endpackage

// ----- hdl/fixed_partition_allocator.sv -----
// Channel | Direction | Handshake                    | Payload
// in      | input     | i_in_valid / o_in_ready      | i_in_data  (fpa_pkg::t_req)
// out     | output    | o_out_valid / i_out_ready    | o_out_data (fpa_pkg::t_rsp)
// cfg     | input     | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_data
//
// One item at a time: accept, then a search of one partition per cycle through a
// single compare unit, then a summing pass over all partitions into the capacity
// and usable-free accumulators, then a final step that forms total free and
// registers the result, which is held while the output side stalls; o_in_ready
// rises the cycle after the result is taken.
// Reset (synchronous, active low) frees every partition, zeroes memory used and
// loads the default capacities.
module fixed_partition_allocator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  fpa_pkg::t_req                          i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output fpa_pkg::t_rsp                          o_out_data,
    input  logic                                   i_cfg_we,
    input  logic [fpa_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [fpa_pkg::CAP_W-1:0]              i_cfg_data
);
    import fpa_pkg::*;

    t_state             r_state, n_state;
    t_req               r_req;
    logic [IDX_W-1:0]   r_idx;
    logic [CAP_W-1:0]   r_cap   [NUM_CFG];
    logic               r_valid [NUM_PARTITIONS];
    logic [PID_W-1:0]   r_pid   [NUM_PARTITIONS];
    logic [CAP_W-1:0]   r_size  [NUM_PARTITIONS];
    logic [MEM_W-1:0]   r_used;
    logic [MEM_W-1:0]   r_cap_sum;
    logic [MEM_W-1:0]   r_usable;
    t_status            r_status;
    logic [PART_W-1:0]  r_part;
    t_rsp               r_out;

    logic               hit;
    logic               last_scan;
    logic               last_sum;
    logic               in_fire;
    logic [CAP_W-1:0]   cur_cap;

    assign in_fire   = i_in_valid && o_in_ready;
    assign cur_cap   = r_cap[r_idx];
    assign last_sum  = (r_idx == IDX_W'(NUM_PARTITIONS - 1));

    // shared compare unit: one partition per cycle
    always_comb begin
        if (r_req.kind == K_ALLOC) begin
            hit       = !r_valid[r_idx] && (cur_cap >= r_req.request_size);
            last_scan = (r_idx == '0);
        end else begin
            hit       = r_valid[r_idx] && (r_pid[r_idx] == r_req.process_id);
            last_scan = last_sum;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_SCAN;
            S_SCAN:  if (hit || last_scan) n_state = S_SUM;
            S_SUM:   if (last_sum) n_state = S_FINAL;
            S_FINAL: n_state = S_DONE;
            S_DONE:  if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = (r_state == S_DONE);
    end

    assign o_out_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            for (int k = 0; k < NUM_PARTITIONS; k++) r_valid[k] <= 1'b0;
            for (int k = 0; k < NUM_CFG; k++) r_cap[k] <= CAP_RESET[k];
        end else begin
            r_state <= n_state;

            if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(NUM_CFG))) begin
                r_cap[i_cfg_idx] <= i_cfg_data;
            end

            if (r_state == S_SCAN && hit) begin
                if (r_req.kind == K_ALLOC) begin
                    r_valid[r_idx] <= 1'b1;
                    r_used         <= r_used + MEM_W'(r_req.request_size);
                end else begin
                    r_valid[r_idx] <= 1'b0;
                    r_used <= (r_used >= MEM_W'(r_size[r_idx]))
                              ? r_used - MEM_W'(r_size[r_idx]) : '0;
                end
            end
        end
    end

    // payload and counters, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_req <= i_in_data;
                    r_idx <= (i_in_data.kind == K_ALLOC) ? IDX_W'(NUM_PARTITIONS - 1) : '0;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    r_status <= (r_req.kind == K_ALLOC) ? ST_GRANTED : ST_RELEASED;
                    r_part   <= PART_W'(r_idx) + PART_W'(1);
                    if (r_req.kind == K_ALLOC) begin
                        r_pid[r_idx]  <= r_req.process_id;
                        r_size[r_idx] <= r_req.request_size;
                    end
                end else if (last_scan) begin
                    r_status <= (r_req.kind == K_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND;
                    r_part   <= '0;
                end
                if (hit || last_scan) begin
                    r_idx     <= '0;
                    r_cap_sum <= '0;
                    r_usable  <= '0;
                end else if (r_req.kind == K_ALLOC) begin
                    r_idx <= r_idx - IDX_W'(1);
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            S_SUM: begin
                r_cap_sum <= r_cap_sum + MEM_W'(cur_cap);
                if (!r_valid[r_idx]) r_usable <= r_usable + MEM_W'(cur_cap);
                if (!last_sum) r_idx <= r_idx + IDX_W'(1);
            end
            S_FINAL: begin
                r_out.status           <= r_status;
                r_out.partition_number <= r_part;
                r_out.memory_used      <= r_used;
                r_out.total_free       <= (r_cap_sum >= r_used) ? r_cap_sum - r_used : '0;
                r_out.usable_free      <= r_usable;
            end
            default: ;
        endcase
    end

endmodule

// ----- hdl/fpa_checker.sv -----
module fpa_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           o_in_ready,
    input  fpa_pkg::t_req  i_in_data,
    input  logic           o_out_valid,
    input  logic           i_out_ready,
    input  fpa_pkg::t_rsp  o_out_data
);
    import fpa_pkg::*;

    t_kind r_kind;

    // kind of the item in flight
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_kind <= i_in_data.kind;
        end
    end

    // a held result must not change under stall
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // one item in flight: no new item while a result is pending
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("ready while result pending");

    // accepted item makes the block busy next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready && !o_out_valid)
        else $error("not busy after accept");

    // partition number non-zero exactly when something was granted or freed
    a_part_vs_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.partition_number != '0) ==
            (o_out_data.status == ST_GRANTED || o_out_data.status == ST_RELEASED)))
        else $error("partition number disagrees with status");

    // an accepted item's kind decides which pair of codes can come back
    a_kind_vs_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.status == ST_RELEASED ||
            o_out_data.status == ST_NOT_FOUND) == (r_kind == K_RELEASE)))
        else $error("status code does not match item kind");

endmodule

bind fixed_partition_allocator fpa_checker u_fpa_checker (.*);

// ----- verif/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fpa_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 4 * NUM_PARTITIONS + 8;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 100;
    localparam int MAX_REPORTS    = 10;

    localparam int REG_SIZE_PART1 = 0;
    localparam int REG_SIZE_PART2 = 1;
    localparam int REG_SIZE_PART3 = 2;
    localparam int REG_SIZE_PART4 = 3;
    localparam int REG_SIZE_PART5 = 4;
    localparam int REG_SIZE_PART6 = 5;
    localparam int REG_IDX_TOP    = (1 << CFG_IDX_W) - 1;

    typedef enum int {
        PLAN_FULL,
        PLAN_RANDOM,
        PLAN_ALTERNATE,
        PLAN_EMPTY,
        PLAN_DEFAULT
    } t_cap_plan;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_req                 i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_rsp                 o_out_data;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [CAP_W-1:0]     i_cfg_data  = '0;

    // partition table as the allocator should hold it
    logic [CAP_W-1:0] cap_now   [NUM_CFG];
    bit               held      [NUM_PARTITIONS];
    logic [PID_W-1:0] held_pid  [NUM_PARTITIONS];
    logic [CAP_W-1:0] held_size [NUM_PARTITIONS];
    int               used_now;

    t_req             req_backlog [$];
    t_rsp             rsp_due     [$];
    logic [PID_W-1:0] pid_pool    [$];

    int items_queued   = 0;
    int results_seen   = 0;
    int mismatches     = 0;
    int cycle_count    = 0;
    int send_gap_pct   = 8;
    int recv_stall_pct = 45;
    int status_seen [4] = '{0, 0, 0, 0};

    t_cap_plan plan_order [RANDOM_PHASES] = '{
        PLAN_FULL, PLAN_RANDOM, PLAN_ALTERNATE, PLAN_EMPTY, PLAN_RANDOM, PLAN_DEFAULT
    };

    fixed_partition_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d results seen",
                     cycle_count, results_seen, items_queued);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // allocate scans from the top partition down, release from the bottom up
    function automatic t_rsp allocate_or_release(t_req r);
        t_rsp rsp;
        int   j;
        int   cap_sum;
        int   free_sum;
        rsp = '0;
        cap_sum = 0;
        free_sum = 0;
        if (r.kind == K_ALLOC) begin
            rsp.status = ST_NO_FIT;
            for (j = NUM_PARTITIONS - 1; j >= 0; j--) begin
                if (!held[j] && cap_now[j] >= r.request_size) begin
                    held[j] = 1'b1;
                    held_pid[j] = r.process_id;
                    held_size[j] = r.request_size;
                    used_now = (used_now + r.request_size) & ((1 << MEM_W) - 1);
                    rsp.status = ST_GRANTED;
                    rsp.partition_number = PART_W'(j + 1);
                    break;
                end
            end
        end else begin
            rsp.status = ST_NOT_FOUND;
            for (j = 0; j < NUM_PARTITIONS; j++) begin
                if (held[j] && held_pid[j] == r.process_id) begin
                    held[j] = 1'b0;
                    // recorded size, not the current capacity
                    used_now = (used_now >= held_size[j]) ? used_now - held_size[j] : 0;
                    rsp.status = ST_RELEASED;
                    rsp.partition_number = PART_W'(j + 1);
                    break;
                end
            end
        end
        for (j = 0; j < NUM_PARTITIONS; j++) begin
            cap_sum += cap_now[j];
            if (!held[j]) begin
                free_sum += cap_now[j];
            end
        end
        rsp.memory_used = MEM_W'(used_now);
        rsp.total_free  = (cap_sum >= used_now) ? MEM_W'(cap_sum - used_now) : '0;
        rsp.usable_free = MEM_W'(free_sum);
        return rsp;
    endfunction

    // input side: expectation formed at acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                rsp_due.push_back(allocate_or_release(i_in_data));
            end
            if (!i_in_valid || o_in_ready) begin
                if (req_backlog.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= req_backlog.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_result(input t_rsp want, input t_rsp got);
        if (got.status !== want.status || got.partition_number !== want.partition_number ||
            got.memory_used !== want.memory_used || got.total_free !== want.total_free ||
            got.usable_free !== want.usable_free) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("mismatch at cycle %0d: status %0d/%0d part %0d/%0d used %0d/%0d",
                         cycle_count, want.status, got.status, want.partition_number,
                         got.partition_number, want.memory_used, got.memory_used);
                $display("    total_free %0d/%0d usable_free %0d/%0d (expected/actual)",
                         want.total_free, got.total_free, want.usable_free, got.usable_free);
            end
        end
    endtask

    // output side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (!$isunknown(o_out_data.status)) begin
                    status_seen[o_out_data.status]++;
                end
                if (rsp_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected result at cycle %0d: status %0d part %0d",
                                 cycle_count, o_out_data.status, o_out_data.partition_number);
                    end
                end else begin
                    check_result(rsp_due.pop_front(), o_out_data);
                end
            end
        end
    end

    task automatic queue_item(input t_kind k, input logic [PID_W-1:0] pid,
                              input logic [CAP_W-1:0] sz);
        t_req r;
        r.kind = k;
        r.process_id = pid;
        r.request_size = sz;
        req_backlog.push_back(r);
        items_queued++;
    endtask

    task automatic write_reg(input int idx, input logic [CAP_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IDX_W'(idx);
        i_cfg_data <= val;
        if (idx < NUM_CFG) begin
            cap_now[idx] = val;
        end
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_plan(input t_cap_plan plan);
        int               k;
        logic [CAP_W-1:0] val;
        for (k = 0; k < NUM_CFG; k++) begin
            case (plan)
                PLAN_FULL:      val = '1;
                PLAN_EMPTY:     val = '0;
                PLAN_ALTERNATE: val = (k % 2 == 0) ? '1 : '0;
                PLAN_DEFAULT:   val = CAP_RESET[k];
                default:        val = CAP_W'($urandom_range(0, 255));
            endcase
            write_reg(REG_SIZE_PART1 + k, val);
        end
        end_writes();
    endtask

    task automatic wait_drained();
        while (results_seen != items_queued) begin
            @(posedge i_clk);
        end
    endtask

    // mostly allocate/release pairs on a small id set, with some stray releases
    task automatic queue_random(input int n);
        int               i;
        int               roll;
        int               slot;
        logic [PID_W-1:0] pid;
        logic [CAP_W-1:0] sz;
        for (i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 35 && pid_pool.size() > 0) begin
                slot = $urandom_range(0, pid_pool.size() - 1);
                pid = pid_pool[slot];
                pid_pool.delete(slot);
                queue_item(K_RELEASE, pid, CAP_W'($urandom));
            end else if (roll < 45) begin
                queue_item(K_RELEASE, PID_W'($urandom), CAP_W'($urandom));
            end else begin
                pid = ($urandom_range(0, 99) < 60) ? PID_W'($urandom_range(0, 15))
                                                   : PID_W'($urandom);
                roll = $urandom_range(0, 99);
                if (roll < 10) begin
                    sz = '0;
                end else if (roll < 30) begin
                    sz = CAP_W'($urandom_range(0, 255));
                end else begin
                    sz = CAP_W'($urandom_range(0, cap_now[$urandom_range(0, NUM_CFG - 1)]));
                end
                pid_pool.push_back(pid);
                queue_item(K_ALLOC, pid, sz);
            end
        end
    endtask

    initial begin
        int ph;
        foreach (cap_now[k]) cap_now[k] = CAP_RESET[k];
        foreach (held[k]) held[k] = 1'b0;
        used_now = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset capacities 40/25/15/10/8/2
        queue_item(K_RELEASE, 16'h0005, 8'd0);     // nothing held yet
        queue_item(K_ALLOC,   16'h0000, 8'd0);     // zero size lands in the top partition
        queue_item(K_ALLOC,   16'hFFFF, 8'd255);   // too big for any partition
        queue_item(K_ALLOC,   16'hFFFF, 8'd40);
        queue_item(K_ALLOC,   16'h0000, 8'd10);    // same id again
        queue_item(K_ALLOC,   16'h1234, 8'd8);
        queue_item(K_RELEASE, 16'h0000, 8'd255);   // lowest-numbered of two freed first
        queue_item(K_RELEASE, 16'h0000, 8'd0);
        queue_item(K_RELEASE, 16'h0000, 8'd0);
        queue_item(K_ALLOC,   16'hA5A5, 8'd25);
        queue_item(K_ALLOC,   16'h5A5A, 8'd15);
        queue_item(K_ALLOC,   16'h0007, 8'd1);
        queue_item(K_ALLOC,   16'h0008, 8'd1);
        queue_item(K_ALLOC,   16'h0009, 8'd0);     // table full
        wait_drained();

        // shrink capacities under occupied partitions; free memory saturates
        write_reg(REG_SIZE_PART6 + 1, 8'hFF);
        write_reg(REG_IDX_TOP, 8'hAA);
        end_writes();
        apply_plan(PLAN_EMPTY);
        queue_item(K_RELEASE, 16'h1234, 8'd0);
        queue_item(K_ALLOC,   16'h000A, 8'd1);
        queue_item(K_ALLOC,   16'h000A, 8'd0);     // zero size fits a zero partition
        queue_item(K_RELEASE, 16'hFFFF, 8'd0);     // subtracts the recorded 40
        queue_item(K_RELEASE, 16'hA5A5, 8'd0);
        queue_item(K_RELEASE, 16'h5A5A, 8'd0);
        wait_drained();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph < 2) begin
                send_gap_pct = 8;
                recv_stall_pct = 45;
            end else if (ph < 4) begin
                send_gap_pct = 45;
                recv_stall_pct = 8;
            end else begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end
            apply_plan(plan_order[ph]);
            queue_random(PHASE_ITEMS);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (rsp_due.size() != 0) begin
            $display("%0d expected results never arrived", rsp_due.size());
            mismatches += rsp_due.size();
        end
        $display("%0d items through %0d capacity settings plus reset values",
                 items_queued, RANDOM_PHASES + 1);
        $display("grants %0d, no fit %0d, releases %0d, unknown ids %0d, mismatches %0d",
                 status_seen[ST_GRANTED], status_seen[ST_NO_FIT], status_seen[ST_RELEASED],
                 status_seen[ST_NOT_FOUND], mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
